// ===== rtl/lc3ie_pkg.sv =====
package lc3ie_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam logic [15:0] START_PC_RST = 16'h3000;

  localparam logic [2:0] CC_NEG  = 3'd4;
  localparam logic [2:0] CC_ZERO = 3'd2;
  localparam logic [2:0] CC_POS  = 3'd1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EXEC = 1'b1;

  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDR  = 4'd6;
  localparam logic [3:0] OP_STR  = 4'd7;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_LDI  = 4'd10;
  localparam logic [3:0] OP_STI  = 4'd11;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_LEA  = 4'd14;

  localparam logic [2:0] R7 = 3'd7;

  typedef struct packed {
    logic        action;
    logic [15:0] load_address;
    logic [15:0] load_data;
    logic [15:0] instruction;
  } in_word_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [2:0]  cond_flags;
    logic        reg_written;
    logic [2:0]  dest_index;
    logic [15:0] dest_value;
    logic        mem_written;
    logic [15:0] store_address;
    logic [15:0] store_value;
    logic        unknown_opcode;
  } out_word_t;

  typedef struct packed {
    logic        we;
    logic [2:0]  addr;
    logic [15:0] data;
  } rf_wr_t;

  function automatic logic [15:0] sext9(input logic [15:0] ins);
    return {{7{ins[8]}}, ins[8:0]};
  endfunction

  function automatic logic [15:0] sext6(input logic [15:0] ins);
    return {{10{ins[5]}}, ins[5:0]};
  endfunction

  function automatic logic [15:0] sext5(input logic [15:0] ins);
    return {{11{ins[4]}}, ins[4:0]};
  endfunction

  function automatic logic [15:0] sext11(input logic [15:0] ins);
    return {{5{ins[10]}}, ins[10:0]};
  endfunction

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    logic [2:0] cc;
    if (v == 16'd0) begin
      cc = CC_ZERO;
    end else if (v[15]) begin
      cc = CC_NEG;
    end else begin
      cc = CC_POS;
    end
    return cc;
  endfunction

endpackage

// ===== rtl/lc3_instruction_execute.sv =====
// lc3 instruction execute unit
// input channel: in_valid / in_stall / in_data carries one word, either a
// memory image load (action 0) or one instruction to execute (action 1)
// output channel: out_valid / out_stall / out_data returns one result word
// per input word: next pc, condition code, register and memory writes
// config: cfg_we / cfg_wdata writes the start pc straight into the pc register
// states from accept to out_valid: EX, then WB for image loads, register ops,
// branches, ST and STR; EX, M1, WB for LD, LDR and STI; EX, M1, M2, WB for
// LDI; one word is in flight at a time, so a new word is taken only after the
// last has left WB; LDI and STI go through the single memory port twice
// reset: registers clear to zero, pc takes 0x3000, condition code zero;
// then a clearing pass writes zero to every memory word, with in_stall
// high; config writes are taken during it
// out_stall holds the result in its output register; one more input word
// is accepted and worked on, then waits until the register is free
module lc3_instruction_execute
  import lc3ie_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [15:0]          mem_wdata;
  logic [15:0]          mem_rdata;
  logic                 rf_rd_en;
  logic [2:0]           rf_ra_addr;
  logic [2:0]           rf_rb_addr;
  logic [15:0]          rf_ra_data;
  logic [15:0]          rf_rb_data;
  rf_wr_t               rf_wr;

  lc3ie_ctrl #(
    .ADDR_BITS(ADDR_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mem_we     (mem_we),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata),
    .rf_rd_en   (rf_rd_en),
    .rf_ra_addr (rf_ra_addr),
    .rf_rb_addr (rf_rb_addr),
    .rf_ra_data (rf_ra_data),
    .rf_rb_data (rf_rb_data),
    .rf_wr      (rf_wr)
  );

  lc3ie_ram #(
    .ADDR_BITS(ADDR_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  lc3ie_rf u_rf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rf_rd_en),
    .ra_addr (rf_ra_addr),
    .rb_addr (rf_rb_addr),
    .ra_data (rf_ra_data),
    .rb_data (rf_rb_data),
    .wr      (rf_wr)
  );

endmodule

// ===== rtl/lc3ie_ram.sv =====
module lc3ie_ram
  import lc3ie_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [15:0]          wdata,
  output logic [15:0]          rdata
);

  logic [15:0] mem [0:(1<<ADDR_BITS)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/lc3ie_rf.sv =====
module lc3ie_rf
  import lc3ie_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rd_en,
  input  logic [2:0]  ra_addr,
  input  logic [2:0]  rb_addr,
  output logic [15:0] ra_data,
  output logic [15:0] rb_data,
  input  rf_wr_t      wr
);

  logic [15:0] mem [0:7];
  logic [7:0]  vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.we) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      ra_data <= vld_r[ra_addr] ? mem[ra_addr] : 16'd0;
      rb_data <= vld_r[rb_addr] ? mem[rb_addr] : 16'd0;
    end
  end

endmodule

// ===== rtl/lc3ie_ctrl.sv =====
module lc3ie_ctrl
  import lc3ie_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  output logic                 mem_we,
  output logic [ADDR_BITS-1:0] mem_addr,
  output logic [15:0]          mem_wdata,
  input  logic [15:0]          mem_rdata,
  output logic                 rf_rd_en,
  output logic [2:0]           rf_ra_addr,
  output logic [2:0]           rf_rb_addr,
  input  logic [15:0]          rf_ra_data,
  input  logic [15:0]          rf_rb_data,
  output rf_wr_t               rf_wr
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EX   = 3'd2;
  localparam logic [2:0] ST_M1   = 3'd3;
  localparam logic [2:0] ST_M2   = 3'd4;
  localparam logic [2:0] ST_WB   = 3'd5;

  localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDR_BITS) - 32'd1);

  logic [2:0]           state_r, state_nxt;
  logic [ADDR_BITS-1:0] clr_cnt_r;
  logic [15:0]          pc_r;
  logic [2:0]           cc_r, cc_nxt;
  in_word_t             item_r;
  out_word_t            res_r, res_nxt;
  out_word_t            res_out;
  logic                 out_valid_r;
  out_word_t            out_data_r;
  logic                 accept;
  logic                 out_free;
  logic [15:0]          ins;
  logic [3:0]           op;
  logic [15:0]          pc1;
  logic [15:0]          pc_off9;
  logic [15:0]          ra_off6;
  logic [15:0]          rb_val;
  logic [3:0]           in_op;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign ins     = item_r.instruction;
  assign op      = ins[15:12];
  assign pc1     = pc_r + 16'd1;
  assign pc_off9 = pc1 + sext9(ins);
  assign ra_off6 = rf_ra_data + sext6(ins);
  assign rb_val  = ins[5] ? sext5(ins) : rf_rb_data;

  // register file read at accept, operands held for the whole item
  assign in_op      = in_data.instruction[15:12];
  assign rf_rd_en   = accept;
  assign rf_ra_addr = in_data.instruction[8:6];
  assign rf_rb_addr = (in_op == OP_ADD || in_op == OP_AND) ?
                      in_data.instruction[2:0] : in_data.instruction[11:9];

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = 16'd0;
    case (state_r)
      ST_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt_r;
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EX;
        end
      end
      ST_EX: begin
        res_nxt         = '0;
        res_nxt.next_pc = pc_r;
        state_nxt       = ST_WB;
        if (item_r.action == ACT_LOAD) begin
          mem_we    = 1'b1;
          mem_addr  = item_r.load_address[ADDR_BITS-1:0];
          mem_wdata = item_r.load_data;
        end else begin
          res_nxt.next_pc = pc1;
          case (op)
            OP_BR: begin
              if ((cc_r & ins[11:9]) != 3'd0) begin
                res_nxt.next_pc = pc_off9;
              end
            end
            OP_ADD: begin
              res_nxt.reg_written = 1'b1;
              res_nxt.dest_index  = ins[11:9];
              res_nxt.dest_value  = rf_ra_data + rb_val;
            end
            OP_AND: begin
              res_nxt.reg_written = 1'b1;
              res_nxt.dest_index  = ins[11:9];
              res_nxt.dest_value  = rf_ra_data & rb_val;
            end
            OP_NOT: begin
              res_nxt.reg_written = 1'b1;
              res_nxt.dest_index  = ins[11:9];
              res_nxt.dest_value  = ~rf_ra_data;
            end
            OP_LEA: begin
              res_nxt.reg_written = 1'b1;
              res_nxt.dest_index  = ins[11:9];
              res_nxt.dest_value  = pc_off9;
            end
            OP_JMP: begin
              res_nxt.next_pc = rf_ra_data;
            end
            OP_JSR: begin
              res_nxt.reg_written = 1'b1;
              res_nxt.dest_index  = R7;
              res_nxt.dest_value  = pc1;
              res_nxt.next_pc     = ins[11] ? pc1 + sext11(ins) : rf_ra_data;
            end
            OP_LD, OP_LDI: begin
              res_nxt.reg_written = 1'b1;
              res_nxt.dest_index  = ins[11:9];
              mem_addr            = pc_off9[ADDR_BITS-1:0];
              state_nxt           = ST_M1;
            end
            OP_LDR: begin
              res_nxt.reg_written = 1'b1;
              res_nxt.dest_index  = ins[11:9];
              mem_addr            = ra_off6[ADDR_BITS-1:0];
              state_nxt           = ST_M1;
            end
            OP_ST: begin
              res_nxt.mem_written   = 1'b1;
              res_nxt.store_address = pc_off9 & ADDR_MASK;
              res_nxt.store_value   = rf_rb_data;
              mem_we                = 1'b1;
              mem_addr              = pc_off9[ADDR_BITS-1:0];
              mem_wdata             = rf_rb_data;
            end
            OP_STR: begin
              res_nxt.mem_written   = 1'b1;
              res_nxt.store_address = ra_off6 & ADDR_MASK;
              res_nxt.store_value   = rf_rb_data;
              mem_we                = 1'b1;
              mem_addr              = ra_off6[ADDR_BITS-1:0];
              mem_wdata             = rf_rb_data;
            end
            OP_STI: begin
              res_nxt.mem_written = 1'b1;
              res_nxt.store_value = rf_rb_data;
              mem_addr            = pc_off9[ADDR_BITS-1:0];
              state_nxt           = ST_M1;
            end
            default: begin
              res_nxt.unknown_opcode = 1'b1;
            end
          endcase
        end
      end
      ST_M1: begin
        state_nxt = ST_WB;
        if (op == OP_LDI) begin
          mem_addr  = mem_rdata[ADDR_BITS-1:0];
          state_nxt = ST_M2;
        end else if (op == OP_STI) begin
          res_nxt.store_address = mem_rdata & ADDR_MASK;
          mem_we                = 1'b1;
          mem_addr              = mem_rdata[ADDR_BITS-1:0];
          mem_wdata             = rf_rb_data;
        end else begin
          res_nxt.dest_value = mem_rdata;
        end
      end
      ST_M2: begin
        res_nxt.dest_value = mem_rdata;
        state_nxt          = ST_WB;
      end
      ST_WB: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cc_nxt = cc_r;
    if (res_r.reg_written && res_r.dest_index != R7) begin
      cc_nxt = cc_of(res_r.dest_value);
    end else if (res_r.reg_written && op != OP_JSR) begin
      cc_nxt = cc_of(res_r.dest_value);
    end
  end

  always_comb begin
    res_out            = res_r;
    res_out.cond_flags = cc_nxt;
  end

  always_comb begin
    rf_wr.we   = (state_r == ST_WB) && out_free && res_r.reg_written;
    rf_wr.addr = res_r.dest_index;
    rf_wr.data = res_r.dest_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      pc_r        <= START_PC_RST;
      cc_r        <= CC_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_BITS'(1);
      end
      if (cfg_we) begin
        pc_r <= cfg_wdata;
      end else if (state_r == ST_WB && out_free) begin
        pc_r <= res_r.next_pc;
      end
      if (state_r == ST_WB && out_free) begin
        cc_r        <= cc_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    res_r <= res_nxt;
    if (state_r == ST_WB && out_free) begin
      out_data_r <= res_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/lc3_exec_checker.sv =====
module lc3_exec_checker
  import lc3ie_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data,
  input  logic      cfg_we,
  input  logic [15:0] cfg_wdata,
  output int        results_due,
  output int        fail_total
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW = ADDR_BITS_DEF;
  localparam int MEM_WORDS = 1 << AW;
  localparam logic [15:0] ADDR_MASK = 16'((32'd1 << AW) - 1);

  logic [15:0] pc_now;
  logic [2:0]  cc_now;
  logic [15:0] gpr [8];
  logic [15:0] image [MEM_WORDS];
  out_word_t   expected_results [$];

  function automatic logic [2:0] flags_for(input logic [15:0] v);
    logic [2:0] f;
    if (v == 16'd0) begin
      f = CC_ZERO;
    end else if (v[15]) begin
      f = CC_NEG;
    end else begin
      f = CC_POS;
    end
    return f;
  endfunction

  function automatic logic [15:0] read_word(input logic [15:0] a);
    return image[a & ADDR_MASK];
  endfunction

  // updates the architectural state and returns the result word
  function automatic out_word_t execute_word(input in_word_t w);
    out_word_t   r;
    logic [15:0] ins, pc, off9, off6, b, base, dval, saddr, sval;
    logic [3:0]  op;
    logic [2:0]  dr, sr1, didx;
    logic        wreg, wmem, unk;
    wreg = 1'b0;
    wmem = 1'b0;
    unk = 1'b0;
    didx = 3'd0;
    dval = 16'd0;
    saddr = 16'd0;
    sval = 16'd0;
    if (w.action == ACT_LOAD) begin
      image[w.load_address & ADDR_MASK] = w.load_data;
    end else begin
      ins = w.instruction;
      op = ins[15:12];
      dr = ins[11:9];
      sr1 = ins[8:6];
      pc = pc_now + 16'd1;
      off9 = {{7{ins[8]}}, ins[8:0]};
      off6 = {{10{ins[5]}}, ins[5:0]};
      case (op)
        OP_BR: begin
          if ((cc_now & dr) != 3'd0) pc = pc + off9;
        end
        OP_ADD, OP_AND: begin
          b = ins[5] ? {{11{ins[4]}}, ins[4:0]} : gpr[ins[2:0]];
          dval = (op == OP_ADD) ? gpr[sr1] + b : gpr[sr1] & b;
          wreg = 1'b1;
        end
        OP_LD: begin
          dval = read_word(pc + off9);
          wreg = 1'b1;
        end
        OP_ST: begin
          saddr = pc + off9;
          sval = gpr[dr];
          wmem = 1'b1;
        end
        OP_JSR: begin
          base = gpr[sr1];
          gpr[R7] = pc;
          didx = R7;
          dval = pc;
          pc = ins[11] ? pc + {{5{ins[10]}}, ins[10:0]} : base;
          wreg = 1'b1;
        end
        OP_LDR: begin
          dval = read_word(gpr[sr1] + off6);
          wreg = 1'b1;
        end
        OP_STR: begin
          saddr = gpr[sr1] + off6;
          sval = gpr[dr];
          wmem = 1'b1;
        end
        OP_NOT: begin
          dval = ~gpr[sr1];
          wreg = 1'b1;
        end
        OP_LDI: begin
          dval = read_word(read_word(pc + off9));
          wreg = 1'b1;
        end
        OP_STI: begin
          saddr = read_word(pc + off9);
          sval = gpr[dr];
          wmem = 1'b1;
        end
        OP_JMP: begin
          pc = gpr[sr1];
        end
        OP_LEA: begin
          dval = pc + off9;
          wreg = 1'b1;
        end
        default: begin
          unk = 1'b1;
        end
      endcase
      if (wreg && op != OP_JSR) begin
        didx = dr;
        gpr[dr] = dval;
        cc_now = flags_for(dval);
      end
      if (wmem) begin
        saddr = saddr & ADDR_MASK;
        image[saddr] = sval;
      end
      pc_now = pc;
    end
    r.next_pc = pc_now;
    r.cond_flags = cc_now;
    r.reg_written = wreg;
    r.dest_index = didx;
    r.dest_value = dval;
    r.mem_written = wmem;
    r.store_address = saddr;
    r.store_value = sval;
    r.unknown_opcode = unk;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_total = fail_total + 1;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want, got;
    if (!rst_n) begin
      pc_now = START_PC_RST;
      cc_now = CC_ZERO;
      for (int i = 0; i < 8; i++) gpr[i] = 16'd0;
      for (int i = 0; i < MEM_WORDS; i++) image[i] = 16'd0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        pc_now = cfg_wdata;
      end
      if (in_valid && !in_stall) expected_results.push_back(execute_word(in_data));
      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_results.size() == 0) begin
          $error("result word with none expected");
          fail_total = fail_total + 1;
        end else begin
          want = expected_results.pop_front();
          check_field("next_pc", want.next_pc, got.next_pc);
          check_field("cond_flags", 16'(want.cond_flags), 16'(got.cond_flags));
          check_field("reg_written", 16'(want.reg_written), 16'(got.reg_written));
          check_field("dest_index", 16'(want.dest_index), 16'(got.dest_index));
          check_field("dest_value", want.dest_value, got.dest_value);
          check_field("mem_written", 16'(want.mem_written), 16'(got.mem_written));
          check_field("store_address", want.store_address, got.store_address);
          check_field("store_value", want.store_value, got.store_value);
          check_field("unknown_opcode", 16'(want.unknown_opcode),
                      16'(got.unknown_opcode));
        end
      end
    end
    results_due = expected_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
module testbench
  import lc3ie_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] OP_RTI  = 4'd8;
  localparam logic [3:0] OP_RSV  = 4'd13;
  localparam logic [3:0] OP_TRAP = 4'd15;
  localparam int DRAIN_CYCLES = 10;
  localparam int LONG_HOLD = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          results_due;
  int          fail_total;
  int          burst_left = 0;
  int          hold_req_cnt = 0;

  always #5 clk = ~clk;

  lc3_instruction_execute u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lc3_exec_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .results_due (results_due),
    .fail_total  (fail_total)
  );

  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left = burst_left - 1;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_load(input logic [15:0] addr, input logic [15:0] data);
    in_word_t w;
    w.action = ACT_LOAD;
    w.load_address = addr;
    w.load_data = data;
    w.instruction = 16'($urandom);
    send_word(w);
  endtask

  task automatic send_exec(input logic [15:0] ins);
    in_word_t w;
    w.action = ACT_EXEC;
    w.load_address = 16'($urandom);
    w.load_data = 16'($urandom);
    w.instruction = ins;
    send_word(w);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_start_pc(input logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // image words near the origin, some of them pointers back into it
  function automatic in_word_t rand_load(input logic [15:0] origin);
    in_word_t w;
    w.action = ACT_LOAD;
    w.load_address = ($urandom_range(0, 99) < 60) ?
                     origin + 16'($urandom_range(0, 1023)) - 16'd512 : 16'($urandom);
    w.load_data = ($urandom_range(0, 1) == 0) ?
                  origin + 16'($urandom_range(0, 1023)) - 16'd512 : 16'($urandom);
    w.instruction = 16'($urandom);
    return w;
  endfunction

  function automatic in_word_t rand_exec();
    in_word_t   w;
    int         p;
    logic [3:0] op;
    p = $urandom_range(0, 99);
    if (p < 12) op = OP_ADD;
    else if (p < 22) op = OP_AND;
    else if (p < 28) op = OP_NOT;
    else if (p < 38) op = OP_BR;
    else if (p < 41) op = OP_JMP;
    else if (p < 45) op = OP_JSR;
    else if (p < 53) op = OP_LD;
    else if (p < 60) op = OP_LDI;
    else if (p < 67) op = OP_LDR;
    else if (p < 74) op = OP_ST;
    else if (p < 80) op = OP_STI;
    else if (p < 86) op = OP_STR;
    else if (p < 95) op = OP_LEA;
    else op = 4'($urandom_range(0, 15));
    w.action = ACT_EXEC;
    w.load_address = 16'($urandom);
    w.load_data = 16'($urandom);
    w.instruction = {op, 12'($urandom)};
    return w;
  endfunction

  // receiver: changing stall patterns plus one long hold-off on request
  initial begin
    int hold_left, mode, mode_left, tick, hold_seen;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    tick = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      tick = tick + 1;
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left = mode_left - 1;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [15:0] phase_pc [5];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = 16'd0;
    phase_pc[0] = 16'h0000;
    phase_pc[1] = 16'hFFFF;
    phase_pc[2] = 16'($urandom);
    phase_pc[3] = START_PC_RST;
    phase_pc[4] = 16'($urandom);
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed
    send_load(16'h0000, 16'hFFFF);
    send_load(16'hFFFF, 16'h8000);
    send_load(16'h3010, 16'h3020);
    send_load(16'h3020, 16'h7FFF);
    send_exec(16'h0000);
    send_exec({OP_ADD, 3'd1, 3'd0, 1'b1, 5'h10});
    send_exec({OP_ADD, 3'd2, 3'd1, 1'b0, 2'b00, 3'd1});
    send_exec({OP_ADD, 3'd0, 3'd0, 1'b1, 5'h0F});
    send_exec({OP_AND, 3'd3, 3'd2, 1'b1, 5'h00});
    send_exec({OP_AND, 3'd4, 3'd1, 1'b0, 2'b11, 3'd2});
    send_exec({OP_NOT, 3'd5, 3'd3, 6'h3F});
    send_exec({OP_LEA, 3'd6, 9'h0FF});
    send_exec({OP_LEA, 3'd6, 9'h100});
    send_exec({OP_LD, 3'd0, 9'h00B});
    send_exec({OP_LDI, 3'd1, 9'h1FF});
    send_exec({OP_LDR, 3'd2, 3'd6, 6'h20});
    send_exec({OP_LDR, 3'd2, 3'd6, 6'h1F});
    send_exec({OP_ST, 3'd5, 9'h100});
    send_exec({OP_STR, 3'd1, 3'd6, 6'h00});
    send_exec({OP_STI, 3'd5, 9'h0FF});
    send_exec({OP_BR, 3'b111, 9'h1FF});
    send_exec({OP_BR, 3'b100, 9'h005});
    send_exec({OP_BR, 3'b011, 9'h002});
    send_exec({OP_JSR, 1'b1, 11'h400});
    send_exec({OP_JSR, 1'b0, 2'b00, R7, 6'h00});
    send_exec({OP_JMP, 3'd0, 3'd6, 6'h00});
    send_exec({OP_RTI, 12'hABC});
    send_exec({OP_RSV, 12'h000});
    send_exec({OP_TRAP, 12'hFFF});

    // random phases, each restarting at its own origin
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      write_start_pc(phase_pc[ph]);
      if (ph == 1 || ph == 3) hold_req_cnt = hold_req_cnt + 1;
      for (int n = 0; n < 240; n++) begin
        if (n < 30 || $urandom_range(0, 99) < 15) begin
          send_word(rand_load(phase_pc[ph]));
        end else begin
          send_word(rand_exec());
        end
      end
    end

    wait_idle();
    if (fail_total == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== lc3_instruction_execute.f =====
rtl/lc3ie_pkg.sv
rtl/lc3ie_ram.sv
rtl/lc3ie_rf.sv
rtl/lc3ie_ctrl.sv
rtl/lc3_instruction_execute.sv
tb/lc3_exec_checker.sv
tb/testbench.sv
